// ----- rtl/core/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle/segment collision test: shared types and constants
// Coordinate widths, derived arithmetic widths and the structs that pass
// between the pipeline halves.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int COORD_BITS  = 16;
	localparam int RADIUS_BITS = 12;
	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(160);

	// Derived arithmetic widths.
	localparam int DW   = COORD_BITS + 1;    // coordinate difference
	localparam int XW   = 2 * DW;            // signed product of two differences
	localparam int SQW  = 2 * COORD_BITS;    // square of a difference
	localparam int SUMW = XW + 1;            // dot and cross products
	localparam int LENW = SQW + 1;           // squared lengths
	localparam int R2W  = 2 * RADIUS_BITS;   // squared radius
	localparam int CLO  = SUMW / 2;          // low part of the cross product
	localparam int CHI  = SUMW - CLO;        // high part of the cross product
	localparam int HHW  = 2 * CHI;
	localparam int LLW  = 2 * CLO;
	localparam int HLW  = CHI + CLO + 1;
	localparam int SUMS = HHW + LLW + 1;     // squared cross product, signed
	localparam int LLO  = LENW / 2;
	localparam int LHI  = LENW - LLO;
	localparam int PHW  = R2W + LHI;
	localparam int PLW  = R2W + LLO;
	localparam int RLW  = R2W + LENW;        // squared radius times squared length

	typedef struct packed {
		logic signed [COORD_BITS-1:0] seg_start_x;
		logic signed [COORD_BITS-1:0] seg_start_y;
		logic signed [COORD_BITS-1:0] seg_end_x;
		logic signed [COORD_BITS-1:0] seg_end_y;
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
	} seg_t;

	typedef struct packed {
		logic signed [XW-1:0] dot_x;     // cx*dx
		logic signed [XW-1:0] dot_y;     // cy*dy
		logic signed [XW-1:0] crs_a;     // cx*dy
		logic signed [XW-1:0] crs_b;     // cy*dx
		logic [SQW-1:0]       sq_dx;
		logic [SQW-1:0]       sq_dy;
		logic [SQW-1:0]       sq_cx;
		logic [SQW-1:0]       sq_cy;
		logic [SQW-1:0]       sq_qx;
		logic [SQW-1:0]       sq_qy;
		logic [R2W-1:0]       r2;
	} prod_t;

	function automatic logic signed [DW-1:0] diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
	endfunction

	function automatic logic signed [XW-1:0] smul(
		input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b
	);
		return a * b;
	endfunction

	// The square of a difference never exceeds SQW bits.
	function automatic logic [SQW-1:0] sq(input logic signed [DW-1:0] a);
		logic signed [XW-1:0] p;
		p = a * a;
		return p[SQW-1:0];
	endfunction

endpackage

// ----- rtl/core/csc_if.sv -----
// ----------------------------------------------------------------------------
// Circle/segment collision test: channel interfaces
// Valid/ready channels for the segment beats and the result beats.
// ----------------------------------------------------------------------------
interface csc_seg_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [csc_pkg::COORD_BITS-1:0] seg_start_x;
	logic signed [csc_pkg::COORD_BITS-1:0] seg_start_y;
	logic signed [csc_pkg::COORD_BITS-1:0] seg_end_x;
	logic signed [csc_pkg::COORD_BITS-1:0] seg_end_y;
	logic signed [csc_pkg::COORD_BITS-1:0] center_x;
	logic signed [csc_pkg::COORD_BITS-1:0] center_y;

	modport source (
		output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, center_x, center_y,
		input  ready
	);
	modport sink (
		input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, center_x, center_y,
		output ready
	);
endinterface

interface csc_hit_if;
	logic valid;
	logic ready;
	logic colliding;

	modport source (output valid, colliding, input ready);
	modport sink (input valid, colliding, output ready);
endinterface

// ----- rtl/core/csc_front.sv -----
// ----------------------------------------------------------------------------
// Circle/segment collision test: front pipeline half
// Stage 1 forms the coordinate differences, stage 2 all 17x17 products and
// the squared radius.
// ----------------------------------------------------------------------------
module csc_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  csc_pkg::seg_t                      seg,
	input  logic [csc_pkg::RADIUS_BITS-1:0]    radius,
	output logic                               out_valid,
	input  logic                               out_ready,
	output csc_pkg::prod_t                     prod
);

	logic v_s1, v_s2;
	logic en_s1, en_s2;

	logic signed [csc_pkg::DW-1:0] dx_s1, dy_s1, cx_s1, cy_s1, qx_s1, qy_s1;
	csc_pkg::prod_t                prod_s2;

	// A stage takes new data when it is empty or its successor moves on.
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dx_s1 <= csc_pkg::diff(seg.seg_end_x, seg.seg_start_x);
			dy_s1 <= csc_pkg::diff(seg.seg_end_y, seg.seg_start_y);
			cx_s1 <= csc_pkg::diff(seg.center_x, seg.seg_start_x);
			cy_s1 <= csc_pkg::diff(seg.center_y, seg.seg_start_y);
			qx_s1 <= csc_pkg::diff(seg.center_x, seg.seg_end_x);
			qy_s1 <= csc_pkg::diff(seg.center_y, seg.seg_end_y);
		end
		if (en_s2 && v_s1) begin
			prod_s2.dot_x <= csc_pkg::smul(cx_s1, dx_s1);
			prod_s2.dot_y <= csc_pkg::smul(cy_s1, dy_s1);
			prod_s2.crs_a <= csc_pkg::smul(cx_s1, dy_s1);
			prod_s2.crs_b <= csc_pkg::smul(cy_s1, dx_s1);
			prod_s2.sq_dx <= csc_pkg::sq(dx_s1);
			prod_s2.sq_dy <= csc_pkg::sq(dy_s1);
			prod_s2.sq_cx <= csc_pkg::sq(cx_s1);
			prod_s2.sq_cy <= csc_pkg::sq(cy_s1);
			prod_s2.sq_qx <= csc_pkg::sq(qx_s1);
			prod_s2.sq_qy <= csc_pkg::sq(qy_s1);
			prod_s2.r2    <= csc_pkg::R2W'(radius) * csc_pkg::R2W'(radius);
		end
	end

	assign out_valid = v_s2;
	assign prod      = prod_s2;

endmodule

// ----- rtl/core/csc_back.sv -----
// ----------------------------------------------------------------------------
// Circle/segment collision test: back pipeline half
// Stage 3 sums the products, stage 4 classifies the projection and splits
// the wide squares into partial products, stage 5 recombines them and
// stage 6 makes the final compare and holds the result.
// ----------------------------------------------------------------------------
module csc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  csc_pkg::prod_t prod,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           colliding
);

	logic v_s3, v_s4, v_s5, v_s6;
	logic en_s3, en_s4, en_s5, en_s6;

	// Stage 3
	logic signed [csc_pkg::SUMW-1:0] t_s3, cr_s3;
	logic [csc_pkg::LENW-1:0]        len2_s3, d0_s3, d1_s3;
	logic [csc_pkg::R2W-1:0]         r2_s3;

	// Stage 4
	logic                           mid_s4, hit_end_s4;
	logic signed [csc_pkg::HHW-1:0] hh_s4;
	logic signed [csc_pkg::HLW-1:0] hl_s4;
	logic [csc_pkg::LLW-1:0]        ll_s4;
	logic [csc_pkg::PHW-1:0]        ph_s4;
	logic [csc_pkg::PLW-1:0]        pl_s4;

	// Stage 5
	logic                            mid_s5, hit_end_s5;
	logic signed [csc_pkg::SUMS-1:0] cr2_s5;
	logic [csc_pkg::RLW-1:0]         rl_s5;

	// Stage 6
	logic colliding_s6;

	// Stage 4 combinational terms
	logic                            le0, ge_len;
	logic [csc_pkg::LENW-1:0]        r2_ext;
	logic signed [csc_pkg::CHI-1:0]  cr_hi;
	logic [csc_pkg::CLO-1:0]         cr_lo;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// The nearest point is the start when the projection is not positive and
	// the end when it reaches the squared length; a zero-length segment
	// always lands on the start.
	assign le0    = t_s3[csc_pkg::SUMW-1] || (t_s3 == '0);
	assign ge_len = t_s3 >= $signed({{(csc_pkg::SUMW - csc_pkg::LENW){1'b0}}, len2_s3});
	assign r2_ext = csc_pkg::LENW'(r2_s3);
	assign cr_hi  = cr_s3[csc_pkg::SUMW-1:csc_pkg::CLO];
	assign cr_lo  = cr_s3[csc_pkg::CLO-1:0];

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			t_s3    <= csc_pkg::SUMW'(prod.dot_x) + csc_pkg::SUMW'(prod.dot_y);
			cr_s3   <= csc_pkg::SUMW'(prod.crs_a) - csc_pkg::SUMW'(prod.crs_b);
			len2_s3 <= csc_pkg::LENW'(prod.sq_dx) + csc_pkg::LENW'(prod.sq_dy);
			d0_s3   <= csc_pkg::LENW'(prod.sq_cx) + csc_pkg::LENW'(prod.sq_cy);
			d1_s3   <= csc_pkg::LENW'(prod.sq_qx) + csc_pkg::LENW'(prod.sq_qy);
			r2_s3   <= prod.r2;
		end
		if (en_s4 && v_s3) begin
			mid_s4     <= !le0 && !ge_len;
			hit_end_s4 <= le0 ? (d0_s3 <= r2_ext) : (d1_s3 <= r2_ext);
			hh_s4      <= cr_hi * cr_hi;
			hl_s4      <= csc_pkg::HLW'(cr_hi) * $signed({1'b0, cr_lo});
			ll_s4      <= csc_pkg::LLW'(cr_lo) * csc_pkg::LLW'(cr_lo);
			ph_s4      <= csc_pkg::PHW'(r2_s3) * csc_pkg::PHW'(len2_s3[csc_pkg::LENW-1:csc_pkg::LLO]);
			pl_s4      <= csc_pkg::PLW'(r2_s3) * csc_pkg::PLW'(len2_s3[csc_pkg::LLO-1:0]);
		end
		if (en_s5 && v_s4) begin
			mid_s5     <= mid_s4;
			hit_end_s5 <= hit_end_s4;
			// The high and low squares do not overlap, so they concatenate; only
			// the doubled middle term needs an adder.
			cr2_s5 <= $signed({1'b0, hh_s4, ll_s4})
				+ $signed({{(csc_pkg::SUMS - csc_pkg::HLW - csc_pkg::CLO - 1){hl_s4[csc_pkg::HLW-1]}},
					hl_s4, {(csc_pkg::CLO + 1){1'b0}}});
			rl_s5  <= csc_pkg::RLW'({ph_s4, {csc_pkg::LLO{1'b0}}}) + csc_pkg::RLW'(pl_s4);
		end
		if (en_s6 && v_s5) begin
			colliding_s6 <= mid_s5
				? (cr2_s5 <= $signed({{(csc_pkg::SUMS - csc_pkg::RLW){1'b0}}, rl_s5}))
				: hit_end_s5;
		end
	end

	assign out_valid = v_s6;
	assign colliding = colliding_s6;

endmodule

// ----- rtl/core/circle_segment_collision_test_top.sv -----
// ----------------------------------------------------------------------------
// Circle/segment collision test: top level
// Tests whether a circle of the programmed radius touches a line segment,
// exactly in integers, one test per cycle while res is not stalled.
//
//   Channel   Dir   Beat contents
//   seg       in    segment start/end and circle center, signed Q12.4
//   res       out   colliding flag
//   cfg       in    radius write (cfg_we, cfg_wdata), no read-back
//
// Six pipeline stages; a beat accepted on seg passes stages 1 to 6 to res,
// and a new beat can enter every cycle while res is not stalled.
// The depth is set by the split squared-cross-product multiply and its
// recombination. Reset clears all valid bits and sets the radius to 160.
// A stall holds every full stage; empty stages still fill behind it.
// ----------------------------------------------------------------------------
module circle_segment_collision_test_top (
	input  logic                            clk,
	input  logic                            arst_n,
	csc_seg_if.sink                         seg,
	csc_hit_if.source                       res,
	input  logic                            cfg_we,
	input  logic [csc_pkg::RADIUS_BITS-1:0] cfg_wdata
);

	logic [csc_pkg::RADIUS_BITS-1:0] radius_q;
	csc_pkg::seg_t                   seg_beat;
	csc_pkg::prod_t                  prod;
	logic                            mid_valid, mid_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= csc_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	assign seg_beat.seg_start_x = seg.seg_start_x;
	assign seg_beat.seg_start_y = seg.seg_start_y;
	assign seg_beat.seg_end_x   = seg.seg_end_x;
	assign seg_beat.seg_end_y   = seg.seg_end_y;
	assign seg_beat.center_x    = seg.center_x;
	assign seg_beat.center_y    = seg.center_y;

	csc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg.valid),
		.in_ready  (seg.ready),
		.seg       (seg_beat),
		.radius    (radius_q),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.prod      (prod)
	);

	csc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.prod      (prod),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.colliding (res.colliding)
	);

endmodule

// ----- rtl/core/csc_checker.sv -----
// ----------------------------------------------------------------------------
// Circle/segment collision test: port checker
// Watches the top-level channels for latency, occupancy and result hold.
// ----------------------------------------------------------------------------
module csc_checker (
	input logic clk,
	input logic arst_n,
	input logic seg_valid,
	input logic seg_ready,
	input logic res_valid,
	input logic res_ready,
	input logic colliding
);

	logic       in_acc, out_acc;
	logic [5:0] acc_hist_q;
	logic [4:0] rdy_hist_q;
	logic [3:0] pend_q;

	assign in_acc  = seg_valid && seg_ready;
	assign out_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_hist_q <= '0;
			rdy_hist_q <= '0;
			pend_q     <= '0;
		end else begin
			acc_hist_q <= {acc_hist_q[4:0], in_acc};
			rdy_hist_q <= {rdy_hist_q[3:0], res_ready};
			pend_q     <= pend_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	// A stalled result keeps its flag.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(colliding))
		else $error("result changed while stalled");

	// With the output never stalled, a beat accepted on seg comes out on res.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc_hist_q[5] && (&rdy_hist_q) && res_ready |-> res_valid)
		else $error("result missing after pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 4'd0)
		else $error("result without an accepted segment beat");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd6)
		else $error("more beats in flight than pipeline stages");

endmodule

bind circle_segment_collision_test_top csc_checker u_csc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.seg_valid (seg.valid),
	.seg_ready (seg.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.colliding (res.colliding)
);

// ----- test/tb_circle_segment_collision_test_top.sv -----
// ----------------------------------------------------------------------------
// Circle/segment collision test: testbench
// Drives segment/center beats through the valid/ready channel under random
// source gaps and sink stalls, and predicts every colliding flag with exact
// wide-integer arithmetic at the programmed radius. The radius is reprogrammed
// between phases, including its extremes, while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_circle_segment_collision_test_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Holds the flags still owed by the block and the radius they were
	// computed with.
	class contact_ledger;
		bit                              expected_flags[$];
		logic [csc_pkg::RADIUS_BITS-1:0] radius = csc_pkg::RADIUS_RESET;
		int                              errors = 0;

		// Exact test: distance from the center to the clamped projection
		// compared against the radius, all in squared form.
		function bit circle_touches(csc_pkg::seg_t s);
			longint     sx, sy, ex, ey, px, py;
			longint     dx, dy, cx, cy, t, len2, r2, cr;
			logic [127:0] cr_mag, cr2, rl;
			sx = $signed(s.seg_start_x);
			sy = $signed(s.seg_start_y);
			ex = $signed(s.seg_end_x);
			ey = $signed(s.seg_end_y);
			px = $signed(s.center_x);
			py = $signed(s.center_y);
			dx = ex - sx;
			dy = ey - sy;
			cx = px - sx;
			cy = py - sy;
			r2 = longint'(radius) * longint'(radius);
			len2 = dx * dx + dy * dy;
			t = cx * dx + cy * dy;
			if (t <= 0)
				return (cx * cx + cy * cy) <= r2;
			if (t >= len2)
				return ((px - ex) * (px - ex) + (py - ey) * (py - ey)) <= r2;
			cr = cx * dy - cy * dx;
			cr_mag = (cr < 0) ? 128'(-cr) : 128'(cr);
			cr2 = cr_mag * cr_mag;
			rl = 128'(r2) * 128'(len2);
			return cr2 <= rl;
		endfunction

		function void note_segment(csc_pkg::seg_t s);
			expected_flags.insert(expected_flags.size(), circle_touches(s));
		endfunction

		function void check_flag(logic got);
			bit want;
			if (expected_flags.size() == 0) begin
				$error("colliding: expected none, actual %0b", got);
				errors++;
				return;
			end
			want = expected_flags.pop_front();
			if (got !== want) begin
				$error("colliding: expected %0b, actual %0b", want, got);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_flags.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [csc_pkg::RADIUS_BITS-1:0] cfg_wdata;
	int unsigned                     calm_left = 0;
	int unsigned                     ready_left = 0;
	contact_ledger                   ledger = new;

	csc_seg_if seg_ch ();
	csc_hit_if res_ch ();

	circle_segment_collision_test_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic csc_pkg::seg_t mk(int ax, int ay, int bx, int by, int qx, int qy);
		csc_pkg::seg_t s;
		s.seg_start_x = 16'(ax);
		s.seg_start_y = 16'(ay);
		s.seg_end_x   = 16'(bx);
		s.seg_end_y   = 16'(by);
		s.center_x    = 16'(qx);
		s.center_y    = 16'(qy);
		return s;
	endfunction

	function automatic int pr(int lo, int hi);
		return lo + int'($urandom_range(hi - lo, 0));
	endfunction

	function automatic int corner();
		case ($urandom_range(3, 0))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	// Offers one beat after a random gap and holds it until it is taken.
	task automatic send_segment(input csc_pkg::seg_t s);
		int unsigned gap;
		int unsigned roll;
		bit          taken;
		gap = 0;
		if (calm_left != 0) begin
			calm_left--;
		end else begin
			roll = $urandom_range(99, 0);
			if (roll < 3)
				calm_left = $urandom_range(60, 20);
			else if (roll < 55)
				gap = 0;
			else if (roll < 85)
				gap = $urandom_range(2, 1);
			else if (roll < 96)
				gap = $urandom_range(6, 3);
			else
				gap = $urandom_range(40, 12);
		end
		if (gap != 0) begin
			seg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seg_ch.seg_start_x <= s.seg_start_x;
		seg_ch.seg_start_y <= s.seg_start_y;
		seg_ch.seg_end_x   <= s.seg_end_x;
		seg_ch.seg_end_y   <= s.seg_end_y;
		seg_ch.center_x    <= s.center_x;
		seg_ch.center_y    <= s.center_y;
		seg_ch.valid       <= 1'b1;
		do begin
			@(posedge clk);
			taken = seg_ch.ready;
			if (taken)
				ledger.note_segment(s);
			@(negedge clk);
		end while (!taken);
	endtask

	// Leaves the block empty: every owed flag back, then a margin with seg idle.
	task automatic drain();
		seg_ch.valid <= 1'b0;
		while (ledger.outstanding() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Result sink: alternating runs of ready and stall, now and then long.
	always @(negedge clk) begin
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else begin
			res_ch.ready <= ~res_ch.ready;
			if (res_ch.ready)
				ready_left <= ($urandom_range(19, 0) == 0) ? $urandom_range(40, 15)
					: $urandom_range(2, 0);
			else
				ready_left <= ($urandom_range(9, 0) == 0) ? $urandom_range(120, 60)
					: $urandom_range(15, 1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			ledger.check_flag(res_ch.colliding);
	end

	initial begin : stimulus
		csc_pkg::seg_t directed[$];
		csc_pkg::seg_t beat;
		int unsigned   radii[7];
		int            bx, by, lx, ly, k, m, ox, oy, r;
		int unsigned   roll;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		res_ch.ready = 1'b0;
		seg_ch.valid = 1'b0;
		seg_ch.seg_start_x = '0;
		seg_ch.seg_start_y = '0;
		seg_ch.seg_end_x = '0;
		seg_ch.seg_end_y = '0;
		seg_ch.center_x = '0;
		seg_ch.center_y = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset radius of 160 throughout the directed beats.
		directed = '{
			mk(-32768, -32768, -32768, -32768, -32768, -32768),
			mk(32767, 32767, 32767, 32767, 32767, 32767),
			mk(-32768, -32768, 32767, 32767, 32767, -32768),
			mk(32767, -32768, -32768, 32767, -32768, -32768),
			mk(100, 100, 100, 100, 260, 100),
			mk(100, 100, 100, 100, 261, 100),
			mk(0, 0, 1000, 0, 500, 160),
			mk(0, 0, 1000, 0, 500, 161),
			mk(0, 0, 1000, 0, 500, -160),
			mk(0, 0, 1000, 0, -160, 0),
			mk(0, 0, 1000, 0, -161, 0),
			mk(0, 0, 1000, 0, 1160, 0),
			mk(0, 0, 1000, 0, 1161, 0),
			mk(0, 0, 1000, 0, 0, 160),
			mk(0, 0, 1000, 0, 0, 161),
			mk(0, 0, 1000, 0, 1000, 160),
			mk(0, 0, 1000, 0, 1000, -161),
			mk(0, 0, 960, 1280, 352, 736),
			mk(0, 0, 960, 1280, 351, 737),
			mk(0, 0, -1000, 0, 96, 128),
			mk(-32768, 0, 32767, 0, 0, 0),
			mk(-32768, 0, 32767, 0, 0, -32768)
		};
		foreach (directed[i])
			send_segment(directed[i]);

		radii = '{160, 0, 4095, 1, $urandom_range(4095, 2), $urandom_range(4095, 2), 2048};
		foreach (radii[p]) begin
			drain();
			cfg_wdata <= csc_pkg::RADIUS_BITS'(radii[p]);
			cfg_we <= 1'b1;
			@(negedge clk);
			cfg_we <= 1'b0;
			ledger.radius = csc_pkg::RADIUS_BITS'(radii[p]);
			r = int'(radii[p]);
			for (int n = 0; n < 155; n++) begin
				roll = $urandom_range(99, 0);
				if (roll < 25) begin
					beat = {$urandom(), $urandom(), $urandom()};
				end else if (roll < 30) begin
					beat = mk(corner(), corner(), corner(), corner(), corner(), corner());
				end else begin
					// A short segment somewhere in the plane with the center
					// placed around it at about one radius.
					bx = pr(-28000, 28000);
					by = pr(-28000, 28000);
					m = 8 << (2 * $urandom_range(4, 0));
					lx = pr(-m, m);
					ly = pr(-m, m);
					case ($urandom_range(4, 0))
						0: ly = 0;
						1: lx = 0;
						2: ly = lx;
						3: begin
							lx = 0;
							ly = 0;
						end
						default: ;
					endcase
					k = $urandom_range(16, 0);
					ox = pr(-(r + 16), r + 16);
					oy = pr(-(r + 16), r + 16);
					case ($urandom_range(7, 0))
						0: begin
							ox = 0;
							oy = r;
						end
						1: begin
							ox = 0;
							oy = -r;
						end
						2: begin
							ox = 0;
							oy = 0;
						end
						default: ;
					endcase
					beat = mk(bx, by, bx + lx, by + ly,
						bx + lx * k / 16 + ox, by + ly * k / 16 + oy);
				end
				send_segment(beat);
			end
		end

		drain();
		if (ledger.errors == 0 && ledger.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/csc_pkg.sv
rtl/core/csc_if.sv
rtl/core/csc_front.sv
rtl/core/csc_back.sv
rtl/core/circle_segment_collision_test_top.sv
rtl/core/csc_checker.sv
test/tb_circle_segment_collision_test_top.sv
